// ----- design/kis_pkg.sv -----
// ----------------------------------------------------------------------------
// kis_pkg: shared definitions for the keyed interval suppressor
// Table geometry, field widths, register indexes, outcome codes and the
// result record of the age comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package kis_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int KEY_W   = 64;
	localparam int TIME_W  = 32;
	localparam int IVL_W   = 31;
	localparam int OUTC_W  = 3;
	localparam int ENTRY_W = KEY_W + TIME_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;

	localparam logic             ENABLE_RST   = 1'b1;
	localparam logic [IVL_W-1:0] INTERVAL_RST = 31'd3600;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_HIT_ALLOW      = 3'd0,
		OUTC_HIT_SUPPRESS   = 3'd1,
		OUTC_INSERTED       = 3'd2,
		OUTC_SWEPT_INSERTED = 3'd3,
		OUTC_UNSTORED       = 3'd4
	} outcome_t;

	typedef struct packed {
		logic ge;	// age not negative and at least the interval
		logic gt;	// age not negative and above the interval
	} age_cmp_t;

endpackage

`default_nettype wire

// ----- design/kis_ram.sv -----
// ----------------------------------------------------------------------------
// kis_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- design/kis_age_cmp.sv -----
// ----------------------------------------------------------------------------
// kis_age_cmp: age comparator shared by lookup and expiry sweep
// Takes the signed age now minus stamp and compares it with the interval.
// ----------------------------------------------------------------------------
`default_nettype none

module kis_age_cmp (
	input  wire logic [kis_pkg::TIME_W-1:0] now,
	input  wire logic [kis_pkg::TIME_W-1:0] stamp,
	input  wire logic [kis_pkg::IVL_W-1:0]  interval,
	output kis_pkg::age_cmp_t                res
);

	import kis_pkg::*;

	logic [TIME_W-1:0] age;
	logic [IVL_W:0]    diff;
	logic              neg;
	logic              ge_mag;

	assign age    = now - stamp;
	assign neg    = age[TIME_W-1];
	// magnitude minus interval; no borrow means age >= interval
	assign diff   = {1'b0, age[IVL_W-1:0]} - {1'b0, interval};
	assign ge_mag = ~diff[IVL_W];

	assign res.ge = ~neg & ge_mag;
	assign res.gt = ~neg & ge_mag & (|diff);

endmodule

`default_nettype wire

// ----- design/keyed_interval_suppressor_core.sv -----
// ----------------------------------------------------------------------------
// keyed_interval_suppressor_core: per-key rate limiter with expiry table
// Keyed lookup, insert and expiry sweep over a table of stamped keys.
// ----------------------------------------------------------------------------
// One request is worked at a time. Keys and stamps sit in one RAM that is
// read one entry per cycle and checked by a single age comparator, so the
// cost is set by the table walk: no walk when disabled, a walk up to entry i
// for a hit at entry i, a walk of all TABLE_ENTRIES for an insert into a
// free slot, and a second full walk for the expiry sweep when the table is
// full. A new request is taken as soon as the previous result has been
// placed in the output register, even if it has not been collected.
// Valid bits are flip-flops cleared by reset; no clearing pass is needed.
`default_nettype none

module keyed_interval_suppressor_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [kis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kis_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [kis_pkg::KEY_W-1:0]     key,
	input  wire logic [kis_pkg::TIME_W-1:0]    now,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               allow,
	output logic [kis_pkg::OUTC_W-1:0]         outcome
);

	import kis_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SWEEP,
		S_WRITE,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic                   enable_q;
	logic [IVL_W-1:0]       interval_q;
	logic [KEY_W-1:0]       key_q;
	logic [TIME_W-1:0]      now_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       idx_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   free_found_q;
	logic [IDX_W-1:0]       tgt_idx_q;
	logic                   res_allow_q;
	outcome_t               res_outc_q;
	logic                   out_valid_q;
	logic                   out_allow_q;
	outcome_t               out_outc_q;

	logic [ENTRY_W-1:0]     ram_rdata;
	logic [TIME_W-1:0]      ram_stamp;
	logic [KEY_W-1:0]       ram_key;
	logic                   ram_we;
	age_cmp_t               age_res;
	logic                   in_acc;
	logic                   issue;
	logic                   entry_valid;
	logic                   key_hit;
	logic                   walk_end;
	logic                   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign allow     = out_allow_q;
	assign outcome   = out_outc_q;

	assign issue       = (idx_q < CNT_W'(TABLE_ENTRIES));
	assign walk_end    = ~issue & ~rd_vld_s1;
	assign ram_key     = ram_rdata[ENTRY_W-1:TIME_W];
	assign ram_stamp   = ram_rdata[TIME_W-1:0];
	assign entry_valid = valid_q[rd_idx_s1];
	assign key_hit     = rd_vld_s1 & entry_valid & (ram_key == key_q);
	assign ram_we      = (state_q == S_WRITE);

	kis_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tgt_idx_q),
		.wdata ({key_q, now_q}),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	kis_age_cmp u_age (
		.now      (now_q),
		.stamp    (ram_stamp),
		.interval (interval_q),
		.res      (age_res)
	);

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= ENABLE_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_INTERVAL: interval_q <= cfg_data[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= key;
			now_q <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			free_found_q <= 1'b0;
			tgt_idx_q    <= '0;
			res_allow_q  <= 1'b0;
			res_outc_q   <= OUTC_UNSTORED;
			out_valid_q  <= 1'b0;
			out_allow_q  <= 1'b0;
			out_outc_q   <= OUTC_UNSTORED;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q        <= '0;
					rd_vld_s1    <= 1'b0;
					free_found_q <= 1'b0;
					if (in_acc) begin
						if (enable_q) begin
							state_q <= S_SEARCH;
						end else begin
							res_allow_q <= 1'b1;
							res_outc_q  <= OUTC_UNSTORED;
							state_q     <= S_DONE;
						end
					end
				end
				S_SEARCH: begin
					// advance the read pointer, evaluate the entry read last cycle
					rd_vld_s1 <= issue & ~key_hit;
					rd_idx_s1 <= idx_q[IDX_W-1:0];
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (key_hit) begin
						tgt_idx_q   <= rd_idx_s1;
						res_allow_q <= age_res.gt;
						res_outc_q  <= age_res.gt ? OUTC_HIT_ALLOW : OUTC_HIT_SUPPRESS;
						state_q     <= S_WRITE;
					end else begin
						if (rd_vld_s1 && !entry_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							tgt_idx_q    <= rd_idx_s1;
						end
						if (walk_end) begin
							idx_q <= '0;
							if (free_found_q) begin
								res_allow_q <= 1'b1;
								res_outc_q  <= OUTC_INSERTED;
								state_q     <= S_WRITE;
							end else begin
								state_q <= S_SWEEP;
							end
						end
					end
				end
				S_SWEEP: begin
					// drop every entry whose age has reached the interval
					rd_vld_s1 <= issue;
					rd_idx_s1 <= idx_q[IDX_W-1:0];
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_vld_s1 && entry_valid && age_res.ge) begin
						valid_q[rd_idx_s1] <= 1'b0;
						if (!free_found_q) begin
							free_found_q <= 1'b1;
							tgt_idx_q    <= rd_idx_s1;
						end
					end
					if (walk_end) begin
						res_allow_q <= 1'b1;
						if (free_found_q) begin
							res_outc_q <= OUTC_SWEPT_INSERTED;
							state_q    <= S_WRITE;
						end else begin
							res_outc_q <= OUTC_UNSTORED;
							state_q    <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					valid_q[tgt_idx_q] <= 1'b1;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_allow_q <= res_allow_q;
						out_outc_q  <= res_outc_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_sweep_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && $past(state_q) == S_SEARCH) |-> (&valid_q))
		else $error("expiry sweep started with a free slot");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |=> valid_q[$past(tgt_idx_q)])
		else $error("written entry not marked valid");

	a_sweep_never_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && $past(state_q) == S_SWEEP) |->
		((valid_q & ~$past(valid_q)) == '0))
		else $error("valid bit set during sweep");

	a_suppress_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_allow_q == 1'b0) == (out_outc_q == OUTC_HIT_SUPPRESS)))
		else $error("allow and outcome disagree");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SEARCH || state_q == S_SWEEP))
		else $error("table read outstanding outside a walk");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyed_interval_suppressor_core
// Drives keyed, time-stamped requests through the valid/stall handshake,
// predicts each allow/outcome verdict with a behavioural copy of the
// expiry table and checks every result in order. It covers hits, inserts,
// expiry sweeps, a full table with nothing freed, a bypassed table and
// several interval settings.
// ----------------------------------------------------------------------------
module testbench;
	import kis_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 100;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
	} request_t;

	typedef struct packed {
		logic     allow;
		outcome_t outcome;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [KEY_W-1:0]      key = '0;
	logic [TIME_W-1:0]     now = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  allow;
	logic [OUTC_W-1:0]     outcome;

	// behavioural copy of the table and registers
	bit                    tbl_valid [TABLE_ENTRIES];
	logic [KEY_W-1:0]      tbl_key   [TABLE_ENTRIES];
	logic [TIME_W-1:0]     tbl_stamp [TABLE_ENTRIES];
	logic                  mdl_enable = ENABLE_RST;
	logic [IVL_W-1:0]      mdl_interval = INTERVAL_RST;

	request_t              pending_requests [$];
	verdict_t              expected_verdicts [$];
	logic [KEY_W-1:0]      issued_keys [$];
	logic [TIME_W-1:0]     gen_clock = '0;
	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	bit                    holding_off = 1'b0;
	int                    failures = 0;

	keyed_interval_suppressor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.key       (key),
		.now       (now),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.allow     (allow),
		.outcome   (outcome)
	);

	always #1 clk = ~clk;

	function automatic verdict_t rate_limit_verdict(input logic [KEY_W-1:0] k,
			input logic [TIME_W-1:0] t);
		verdict_t          v;
		logic [TIME_W-1:0] age;
		int                hit;
		int                slot;
		int                freed;
		v.allow = 1'b1;
		v.outcome = OUTC_UNSTORED;
		hit = -1;
		slot = -1;
		freed = 0;
		if (mdl_enable) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (hit < 0 && tbl_valid[i] && tbl_key[i] == k)
					hit = i;
			if (hit >= 0) begin
				// top bit of the difference set means a negative age
				age = t - tbl_stamp[hit];
				v.allow = !age[TIME_W-1] && (age[IVL_W-1:0] > mdl_interval);
				v.outcome = v.allow ? OUTC_HIT_ALLOW : OUTC_HIT_SUPPRESS;
				tbl_stamp[hit] = t;
			end else begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (slot < 0 && !tbl_valid[i])
						slot = i;
				if (slot < 0) begin
					// table full: drop every entry that has reached the interval
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						age = t - tbl_stamp[i];
						if (tbl_valid[i] && !age[TIME_W-1] &&
								age[IVL_W-1:0] >= mdl_interval) begin
							tbl_valid[i] = 1'b0;
							freed++;
						end
					end
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (slot < 0 && !tbl_valid[i])
							slot = i;
				end
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b1;
					tbl_key[slot] = k;
					tbl_stamp[slot] = t;
					v.outcome = (freed != 0) ? OUTC_SWEPT_INSERTED : OUTC_INSERTED;
				end
			end
		end
		return v;
	endfunction

	always @(posedge clk) begin : request_driver
		request_t req;
		bit       busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				expected_verdicts.push_back(rate_limit_verdict(key, now));
				busy = 1'b0;
			end
			// hold the transaction while stalled
			if (!busy) begin
				if (holding_off && expected_verdicts.size() == 0)
					holding_off = 1'b0;
				if (!holding_off && pending_requests.size() != 0 &&
						$urandom_range(0, 63) == 0)
					holding_off = 1'b1;
				if (!holding_off && pending_requests.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					req = pending_requests.pop_front();
					in_valid <= 1'b1;
					key <= req.key;
					now <= req.now;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		verdict_t exp_v;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result: allow %0b, outcome %0d", allow, outcome);
					failures++;
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (allow !== exp_v.allow) begin
						$error("allow: expected %0b, actual %0b", exp_v.allow, allow);
						failures++;
					end
					if (outcome !== exp_v.outcome) begin
						$error("outcome: expected %0d, actual %0d", exp_v.outcome, outcome);
						failures++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic queue_request(input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] t);
		request_t r;
		r.key = k;
		r.now = t;
		pending_requests.push_back(r);
		issued_keys.push_back(k);
	endtask

	task automatic queue_random(input int count, input int new_pct, input int max_step);
		logic [KEY_W-1:0]  k;
		logic [TIME_W-1:0] t;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < new_pct || issued_keys.size() == 0)
				k = {$urandom(), $urandom()};
			else
				k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
			// mostly a steady clock; now and then a stray absolute time
			if ($urandom_range(0, 9) == 0) begin
				t = $urandom();
			end else begin
				gen_clock = gen_clock + $urandom_range(0, max_step);
				t = gen_clock;
			end
			queue_request(k, t);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		if (idx == REG_ENABLE)
			mdl_enable = data[0];
		else if (idx == REG_INTERVAL)
			mdl_interval = data;
	endtask

	task automatic wait_until_quiet;
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_verdicts.size() != 0);
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 50;

		// age equal to, just above, and wrapped past the interval
		queue_request('0, 32'd0);
		queue_request('0, 32'd3600);
		queue_request('0, 32'd7201);
		queue_request('1, 32'hFFFF_FFFF);
		queue_request('1, 32'd0);
		queue_request('0, 32'h8000_1C21);
		queue_request('0, 32'h8000_1C20);
		queue_request(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		wait_until_quiet();

		write_reg(REG_INTERVAL, '0);
		queue_request(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		queue_request(64'h5555_5555_5555_5555, 32'hAAAA_AAAB);
		wait_until_quiet();

		write_reg(REG_INTERVAL, '1);
		queue_request(64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		queue_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h7FFF_FFFF);
		queue_request(64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
		wait_until_quiet();

		// bypass the table; writes to spare indexes must change nothing
		write_reg(REG_ENABLE, 31'h7FFF_FFFE);
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '1);
		queue_request('0, 32'd0);
		queue_request({$urandom(), $urandom()}, $urandom());
		queue_request('1, 32'd5);
		wait_until_quiet();

		// table contents survive the bypass
		write_reg(REG_ENABLE, 31'd1);
		write_reg(REG_INTERVAL, INTERVAL_RST);
		queue_request('0, 32'h8000_2C32);
		queue_request('1, 32'd3602);
		wait_until_quiet();

		// fill the table
		queue_random(260, 95, 3000);
		wait_until_quiet();

		send_idle_pct = 50;
		recv_idle_pct = 15;
		// full table, nothing old enough to sweep
		write_reg(REG_INTERVAL, '1);
		queue_random(60, 50, 3000);
		wait_until_quiet();

		write_reg(REG_INTERVAL, 31'd20000);
		queue_random(60, 60, 5000);
		wait_until_quiet();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_INTERVAL, '0);
		queue_random(40, 10, 2);
		wait_until_quiet();

		write_reg(REG_ENABLE, 31'd0);
		queue_random(10, 50, 100);
		wait_until_quiet();

		write_reg(REG_ENABLE, 31'd1);
		write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(1, 1000)));
		queue_random(30, 40, 600);
		wait_until_quiet();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- keyed_interval_suppressor_core.f -----
design/kis_pkg.sv
design/kis_ram.sv
design/kis_age_cmp.sv
design/keyed_interval_suppressor_core.sv
dv/testbench.sv
